### rtl/core/scan_order_index_generator_core_assert.svh
// Assertion macros shared by the scan order core.
`ifndef SCAN_ORDER_INDEX_GENERATOR_CORE_ASSERT_SVH
`define SCAN_ORDER_INDEX_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define SOGEN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SOGEN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/sogen_pkg.sv
package sogen_pkg;

	// Grid and index sizes
	localparam int MAX_SIDE = 256;
	localparam int Q_W      = $clog2(MAX_SIDE);   // quotient bits, one per divider cell
	localparam int SIDE_W   = Q_W + 1;            // side register width, holds MAX_SIDE
	localparam int N_W      = 2 * SIDE_W - 1;     // token count width, holds MAX_SIDE squared
	localparam int TOKEN_W  = 16;
	localparam int NUM_CELLS = Q_W;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		KIND_CYCLE  = 2'd0,
		KIND_HSNAKE = 2'd1,
		KIND_VSNAKE = 2'd2,
		KIND_RASTER = 2'd3
	} scan_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEIGHT  = 3'd0,
		REG_WIDTH   = 3'd1,
		REG_KIND    = 3'd2,
		REG_PHASE   = 3'd3,
		REG_SCATTER = 3'd4
	} cfg_reg_t;

	// Settings seen by the datapath (sides already clamped)
	typedef struct packed {
		logic [SIDE_W-1:0] h;
		logic [SIDE_W-1:0] w;
		logic [N_W-1:0]    n;
		scan_kind_t        kind;
		logic [1:0]        phase;
		logic              scatter;
	} cfg_t;

	// Word moving along the divider cells
	typedef struct packed {
		logic [TOKEN_W-1:0] t;
		logic [TOKEN_W-1:0] k;
		logic [TOKEN_W-1:0] rem;
		logic [TOKEN_W-1:0] dsh;
		logic [Q_W-1:0]     q;
		logic               err;
		logic               raster;
		logic               vertical;
	} div_word_t;

	// Word after row/column fold, before the multiply-add
	typedef struct packed {
		logic [TOKEN_W-1:0] t;
		logic [TOKEN_W-1:0] k;
		logic [Q_W-1:0]     mul_a;
		logic [Q_W-1:0]     add_b;
		logic               err;
		logic               raster;
	} fold_word_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] s);
		return (s > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : s;
	endfunction

endpackage

### rtl/core/scan_order_index_generator_core.sv
// Scan order index generator.
// Input stream: s_tdata carries one token position per word. Output stream: m_tdata
// carries the source and destination token indices, m_tuser flags a position at or
// beyond height*width (both indices are then zero).
// Configuration: cfg_valid/cfg_index/cfg_data write height, width, scan kind, phase
// and scatter mode; cfg_ready is always high. Write only while the core is empty.
// Between an accepted input word and m_tvalid lie the front stage, the chain of 8
// divider cells (one quotient bit each) that splits the scan step into row and column,
// and the fold and output stages; one word enters every cycle unless the chain is full.
// Every stage has its own valid register and ready is passed back stage by stage,
// so a stalled receiver only holds words that are already waiting; empty stages
// keep filling until the chain is full, then s_tready drops.
// Reset clears all valid bits and sets height and width to 1, other settings to 0;
// the core accepts words in the first cycle after reset.
module scan_order_index_generator_core
	import sogen_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TOKEN_W-1:0]   s_tdata,   // [15:0] token_position
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [2*TOKEN_W-1:0] m_tdata,   // [15:0] source_token, [31:16] destination_token
	output logic                 m_tuser,   // [0] position_error
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIDE_W-1:0]    cfg_data
);

	`include "scan_order_index_generator_core_assert.svh"

	logic [SIDE_W-1:0] height_q;
	logic [SIDE_W-1:0] width_q;
	scan_kind_t        kind_q;
	logic [1:0]        phase_q;
	logic              scatter_q;
	cfg_t              cfg;

	logic      chain_valid [NUM_CELLS+1];
	logic      chain_ready [NUM_CELLS+1];
	div_word_t chain_word  [NUM_CELLS+1];

	logic [TOKEN_W-1:0] src;
	logic [TOKEN_W-1:0] dst;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q  <= SIDE_W'(1);
			width_q   <= SIDE_W'(1);
			kind_q    <= KIND_CYCLE;
			phase_q   <= '0;
			scatter_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HEIGHT:  height_q  <= cfg_data;
				REG_WIDTH:   width_q   <= cfg_data;
				REG_KIND:    kind_q    <= scan_kind_t'(cfg_data[1:0]);
				REG_PHASE:   phase_q   <= cfg_data[1:0];
				REG_SCATTER: scatter_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamped sides and token count, valid in the cycle after a write
	always_comb begin
		cfg.h       = clamp_side(height_q);
		cfg.w       = clamp_side(width_q);
		cfg.n       = N_W'(clamp_side(height_q) * clamp_side(width_q));
		cfg.kind    = kind_q;
		cfg.phase   = phase_q;
		cfg.scatter = scatter_q;
	end

	sogen_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_t      (s_tdata),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_word  (chain_word[0])
	);

	// Divider chain, one quotient bit per cell
	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		sogen_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_word   (chain_word[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_word  (chain_word[i+1])
		);
	end

	sogen_index u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (chain_valid[NUM_CELLS]),
		.in_ready  (chain_ready[NUM_CELLS]),
		.in_word   (chain_word[NUM_CELLS]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_src   (src),
		.out_dst   (dst),
		.out_err   (m_tuser)
	);

	assign m_tdata = {dst, src};

	// Checks
	`SOGEN_ASSERT_NOW(a_err_zero, m_tvalid && m_tuser, m_tdata == '0, "error word with nonzero index")
	`SOGEN_ASSERT_NOW(a_src_range, m_tvalid && !m_tuser, {1'b0, src} < cfg.n, "source index outside grid")
	`SOGEN_ASSERT_NOW(a_dst_range, m_tvalid && !m_tuser, {1'b0, dst} < cfg.n, "destination index outside grid")
	`SOGEN_ASSERT_NOW(a_raster_id, m_tvalid && !m_tuser && kind_q == KIND_RASTER && !phase_q[0], src == dst, "forward raster is not identity")

endmodule

### rtl/core/sogen_front.sv
// Range check, scan reversal and divisor setup; one register stage.
module sogen_front
	import sogen_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TOKEN_W-1:0] in_t,
	output logic               out_valid,
	input  logic               out_ready,
	output div_word_t          out_word
);

	logic        valid_q;
	div_word_t   word_q;
	div_word_t   word_d;
	logic [N_W-1:0] t_ext;
	logic [N_W-1:0] k_rev;
	logic        vertical;
	logic [SIDE_W-1:0] divisor;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	// Decode scan kind, reverse position, pick divisor
	always_comb begin
		t_ext = {{(N_W-TOKEN_W){1'b0}}, in_t};
		k_rev = cfg.n - N_W'(1) - t_ext;
		unique case (cfg.kind)
			KIND_VSNAKE: vertical = 1'b1;
			KIND_CYCLE:  vertical = cfg.phase[1];
			default:     vertical = 1'b0;
		endcase
		divisor = vertical ? cfg.h : cfg.w;

		word_d.t        = in_t;
		word_d.err      = (t_ext >= cfg.n);
		word_d.k        = cfg.phase[0] ? k_rev[TOKEN_W-1:0] : in_t;
		word_d.rem      = word_d.k;
		word_d.dsh      = TOKEN_W'({divisor, {(Q_W-1){1'b0}}});
		word_d.q        = '0;
		word_d.raster   = (cfg.kind == KIND_RASTER);
		word_d.vertical = vertical;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q <= word_d;
		end
	end

endmodule

### rtl/core/sogen_div_cell.sv
// One restoring-division cell: settles one quotient bit and hands the word on.
module sogen_div_cell
	import sogen_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_word_t in_word,
	output logic      out_valid,
	input  logic      out_ready,
	output div_word_t out_word
);

	logic      valid_q;
	div_word_t word_q;
	div_word_t word_d;
	logic      fits;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	// Trial subtract of the shifted divisor
	always_comb begin
		fits       = (in_word.rem >= in_word.dsh);
		word_d     = in_word;
		word_d.rem = fits ? (in_word.rem - in_word.dsh) : in_word.rem;
		word_d.q   = {in_word.q[Q_W-2:0], fits};
		word_d.dsh = in_word.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_q <= word_d;
		end
	end

endmodule

### rtl/core/sogen_index.sv
// Snake fold, row*width+column multiply-add and output register.
module sogen_index
	import sogen_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  div_word_t          in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [TOKEN_W-1:0] out_src,
	output logic [TOKEN_W-1:0] out_dst,
	output logic               out_err
);

	logic               valid_s1;
	logic               valid_s2;
	logic               ready_s1;
	logic               ready_s2;
	fold_word_t         fold_s1;
	fold_word_t         fold_d;
	logic [Q_W-1:0]     minor;
	logic [Q_W-1:0]     w_fold;
	logic [Q_W-1:0]     h_fold;
	logic [Q_W+SIDE_W-1:0] mac;
	logic [TOKEN_W-1:0] scan;
	logic [TOKEN_W-1:0] src_s2;
	logic [TOKEN_W-1:0] dst_s2;
	logic               err_s2;
	logic [TOKEN_W-1:0] src_d;
	logic [TOKEN_W-1:0] dst_d;

	assign ready_s2  = !valid_s2 || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;
	assign out_valid = valid_s2;
	assign out_src   = src_s2;
	assign out_dst   = dst_s2;
	assign out_err   = err_s2;

	// Odd rows (or columns) run backward
	always_comb begin
		minor  = in_word.rem[Q_W-1:0];
		w_fold = Q_W'(cfg.w - SIDE_W'(1) - {1'b0, minor});
		h_fold = Q_W'(cfg.h - SIDE_W'(1) - {1'b0, minor});
		fold_d.t      = in_word.t;
		fold_d.k      = in_word.k;
		fold_d.err    = in_word.err;
		fold_d.raster = in_word.raster;
		if (in_word.vertical) begin
			fold_d.mul_a = in_word.q[0] ? h_fold : minor;
			fold_d.add_b = in_word.q;
		end else begin
			fold_d.mul_a = in_word.q;
			fold_d.add_b = in_word.q[0] ? w_fold : minor;
		end
	end

	// Token index and gather/scatter swap
	always_comb begin
		mac  = fold_s1.mul_a * cfg.w + (Q_W+SIDE_W)'(fold_s1.add_b);
		scan = fold_s1.raster ? fold_s1.k : mac[TOKEN_W-1:0];
		if (fold_s1.err) begin
			src_d = '0;
			dst_d = '0;
		end else if (cfg.scatter) begin
			src_d = fold_s1.t;
			dst_d = scan;
		end else begin
			src_d = scan;
			dst_d = fold_s1.t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			fold_s1 <= fold_d;
		end
		if (valid_s1 && ready_s2) begin
			src_s2 <= src_d;
			dst_s2 <= dst_d;
			err_s2 <= fold_s1.err;
		end
	end

endmodule

### test/tb.sv
`timescale 1ns / 100ps

module tb;
	import sogen_pkg::*;

	localparam int PIPE_LATENCY   = 10;
	localparam int DRAIN_CYCLES   = PIPE_LATENCY + 4;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_PRINTS     = 40;
	localparam int HOLD_CYCLES    = 60;

	// One expected output word
	typedef struct packed {
		logic [TOKEN_W-1:0] src;
		logic [TOKEN_W-1:0] dst;
		logic               err;
	} index_pair_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TOKEN_W-1:0]   s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [2*TOKEN_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SIDE_W-1:0]    cfg_data;

	// Local copy of the register file
	logic [SIDE_W-1:0] grid_rows;
	logic [SIDE_W-1:0] grid_cols;
	logic [1:0]        order_kind;
	logic [1:0]        order_phase;
	logic              scatter_on;

	index_pair_t pending_pairs[$];
	int          mismatch_count;
	int          quiet_cycles;
	int          hold_left;
	int          stall_left;
	bit          src_idle_on;
	bit          sink_idle_on;

	scan_order_index_generator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Number of tokens in the grid, sides limited to MAX_SIDE
	function automatic int unsigned grid_tokens();
		int unsigned h;
		int unsigned w;
		h = (grid_rows > MAX_SIDE) ? MAX_SIDE : grid_rows;
		w = (grid_cols > MAX_SIDE) ? MAX_SIDE : grid_cols;
		return h * w;
	endfunction

	// Source/destination pair for one position under the current settings
	function automatic index_pair_t scan_pair(input logic [TOKEN_W-1:0] pos);
		int unsigned h;
		int unsigned w;
		int unsigned n;
		int unsigned t;
		int unsigned k;
		int unsigned major;
		int unsigned minor;
		int unsigned scan;
		bit          vertical;
		bit          raster;
		index_pair_t r;
		h = (grid_rows > MAX_SIDE) ? MAX_SIDE : grid_rows;
		w = (grid_cols > MAX_SIDE) ? MAX_SIDE : grid_cols;
		n = h * w;
		t = pos;
		r = '0;
		if (t >= n) begin
			r.err = 1'b1;
			return r;
		end
		vertical = 1'b0;
		raster   = 1'b0;
		case (scan_kind_t'(order_kind))
			KIND_RASTER: raster = 1'b1;
			KIND_VSNAKE: vertical = 1'b1;
			KIND_CYCLE:  vertical = order_phase[1];
			default: ;
		endcase
		// phase bit 0 walks the scan backward in every kind
		k = order_phase[0] ? (n - 1 - t) : t;
		if (raster) begin
			scan = k;
		end else if (!vertical) begin
			major = k / w;
			minor = k - major * w;
			scan  = major * w + (major[0] ? (w - 1 - minor) : minor);
		end else begin
			major = k / h;
			minor = k - major * h;
			scan  = (major[0] ? (h - 1 - minor) : minor) * w + major;
		end
		if (scatter_on) begin
			r.src = TOKEN_W'(t);
			r.dst = TOKEN_W'(scan);
		end else begin
			r.src = TOKEN_W'(scan);
			r.dst = TOKEN_W'(t);
		end
		return r;
	endfunction

	function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
			input logic [SIDE_W-1:0] data);
		case (idx)
			REG_HEIGHT:  grid_rows = data;
			REG_WIDTH:   grid_cols = data;
			REG_KIND:    order_kind = data[1:0];
			REG_PHASE:   order_phase = data[1:0];
			REG_SCATTER: scatter_on = data[0];
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [TOKEN_W-1:0] got,
			input logic [TOKEN_W-1:0] want);
		if (mismatch_count < MAX_PRINTS)
			$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Send one position word; called and returns at a falling edge
	task automatic send_position(input logic [TOKEN_W-1:0] pos);
		if (src_idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pos;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_pairs.push_back(scan_pair(pos));
		@(negedge clk);
	endtask

	// One register write; valid is left high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIDE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_setting(idx, data);
		@(negedge clk);
	endtask

	task automatic program_grid(input logic [SIDE_W-1:0] h, input logic [SIDE_W-1:0] w,
			input logic [SIDE_W-1:0] kind, input logic [SIDE_W-1:0] phase,
			input logic [SIDE_W-1:0] scatter);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_KIND, kind);
		write_reg(REG_PHASE, phase);
		write_reg(REG_SCATTER, scatter);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Wait for every expected word, then let the pipe settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [SIDE_W-1:0] random_side();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return SIDE_W'($urandom_range(MAX_SIDE + 1, 2 * MAX_SIDE - 1));
			2:       return SIDE_W'(MAX_SIDE);
			3:       return SIDE_W'($urandom_range(25, MAX_SIDE - 1));
			default: return SIDE_W'($urandom_range(1, 24));
		endcase
	endfunction

	// Mostly valid positions, some just past the end, some anywhere
	function automatic logic [TOKEN_W-1:0] random_position();
		int unsigned n;
		int          pick;
		n    = grid_tokens();
		pick = $urandom_range(0, 19);
		if (n == 0 || pick < 3)
			return TOKEN_W'($urandom_range(0, 65535));
		if (pick < 6)
			return TOKEN_W'(n + $urandom_range(0, 3));
		if (pick < 8)
			return (pick == 6) ? '0 : TOKEN_W'(n - 1);
		return TOKEN_W'($urandom_range(0, n - 1));
	endfunction

	task automatic test_reset_values();
		send_position('0);
		send_position(16'd1);
		send_position(16'hFFFF);
		wait_drained();
	endtask

	task automatic test_directed_cases();
		int i;
		// 3x5, four-way cycle in its vertical reversed phase
		program_grid(9'd3, 9'd5, SIDE_W'(KIND_CYCLE), 9'd3, 9'd0);
		send_position(16'd0);
		send_position(16'd6);
		send_position(16'd14);
		send_position(16'd15);
		wait_drained();
		// horizontal snake ignores phase bit 1, scatter direction
		program_grid(9'd3, 9'd5, SIDE_W'(KIND_HSNAKE), 9'd2, 9'd1);
		send_position(16'd7);
		send_position(16'd14);
		wait_drained();
		program_grid(9'd3, 9'd5, SIDE_W'(KIND_VSNAKE), 9'd1, 9'd0);
		send_position(16'd5);
		send_position(16'd9);
		wait_drained();
		program_grid(9'd3, 9'd5, SIDE_W'(KIND_RASTER), 9'd1, 9'd1);
		send_position(16'd0);
		send_position(16'd14);
		wait_drained();
		// zero height: nothing is in range
		program_grid(9'd0, 9'd256, SIDE_W'(KIND_CYCLE), 9'd0, 9'd0);
		send_position(16'd0);
		send_position(16'hFFFF);
		wait_drained();
		// oversized sides fall back to the largest grid
		program_grid(9'd511, 9'd257, SIDE_W'(KIND_CYCLE), 9'd0, 9'd0);
		send_position(16'hFFFF);
		send_position(16'h5555);
		send_position(16'hAAAA);
		wait_drained();
		// writes to unused register numbers must change nothing
		for (i = REG_SCATTER + 1; i < 2 ** CFG_IDX_W; i++)
			write_reg(CFG_IDX_W'(i), SIDE_W'($urandom_range(0, 2 * MAX_SIDE - 1)));
		cfg_valid <= 1'b0;
		@(negedge clk);
		send_position(16'hFFFF);
		send_position(16'd256);
		wait_drained();
	endtask

	task automatic run_grid(input int items);
		int i;
		program_grid(random_side(), random_side(),
			SIDE_W'($urandom_range(0, 511)), SIDE_W'($urandom_range(0, 511)),
			SIDE_W'($urandom_range(0, 511)));
		for (i = 0; i < items; i++)
			send_position(random_position());
		wait_drained();
	endtask

	task automatic test_random_grids();
		int g;
		for (g = 0; g < 14; g++) begin
			src_idle_on  = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			run_grid(100);
		end
	endtask

	// Receiver stops for a long stretch while words keep coming
	task automatic test_output_hold_off();
		int i;
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		program_grid(SIDE_W'($urandom_range(2, 20)), SIDE_W'($urandom_range(2, 20)),
			SIDE_W'($urandom_range(0, 511)), SIDE_W'($urandom_range(0, 511)),
			SIDE_W'($urandom_range(0, 511)));
		hold_left = HOLD_CYCLES;
		for (i = 0; i < 40; i++)
			send_position(random_position());
		wait_drained();
	endtask

	task automatic test_back_to_back();
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		run_grid(80);
	endtask

	// Receiver: random stall bursts and the requested hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 7) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each output word with the oldest expected pair
	always @(posedge clk) begin
		index_pair_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pairs.size() == 0) begin
				report_mismatch("unexpected word", m_tdata[TOKEN_W-1:0], '0);
			end else begin
				want = pending_pairs.pop_front();
				if (m_tdata[TOKEN_W-1:0] !== want.src)
					report_mismatch("source_token", m_tdata[TOKEN_W-1:0], want.src);
				if (m_tdata[2*TOKEN_W-1:TOKEN_W] !== want.dst)
					report_mismatch("destination_token", m_tdata[2*TOKEN_W-1:TOKEN_W],
						want.dst);
				if (m_tuser !== want.err)
					report_mismatch("position_error", TOKEN_W'(m_tuser), TOKEN_W'(want.err));
			end
		end
	end

	// Watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		hold_left      = 0;
		stall_left     = 0;
		src_idle_on    = 1'b1;
		sink_idle_on   = 1'b1;
		grid_rows      = SIDE_W'(1);
		grid_cols      = SIDE_W'(1);
		order_kind     = KIND_CYCLE;
		order_phase    = '0;
		scatter_on     = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_values();
		test_directed_cases();
		test_random_grids();
		test_output_hold_off();
		test_back_to_back();

		if (mismatch_count == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
